### rtl/ssk_pkg.sv
// shared types and codes for the sorted key set
package ssk_pkg;

  localparam int KEY_W = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIRST  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [1:0] {
    TK_SEARCH,
    TK_INSERT,
    TK_SHIFT,
    TK_DONE
  } tstate_t;

  typedef struct packed {
    logic             active;
    tstate_t          st;
    logic [1:0]       mode;
    logic [1:0]       status;
    logic             full;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] carry;
    logic [KEY_W-1:0] removed;
  } tok_t;

endpackage

### rtl/sorted_key_set_top.sv
// sorted key set: request control and the chain of key cells
//
//  channel        dir  handshake                  content
//  s_axis         in   tvalid/tready              request item (mode, key)
//  m_axis         out  tvalid/tready              result item (status, out_key, count)
//  cfg            in   cfg_wr_en                  order_descending
//
// a request token walks the cell chain one cell per cycle; m_axis_tvalid rises
// once the token has left the last cell, so the chain length sets the latency.
// one item is in work at a time; s_axis_tready is low while a token is in the
// chain or a result waits on m_axis, so a new item is taken only once the last
// result has been taken from m_axis. reset empties the store and the chain.
module sorted_key_set_top #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // mode [1:0], key [33:2], zero fill
  input  logic [((2+ssk_pkg::KEY_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status [1:0], out_key [33:2], count [33+CNT_W:34], zero fill
  output logic [((2+ssk_pkg::KEY_W+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata
);
  import ssk_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             order_desc;
  logic             busy;
  logic [CNT_W-1:0] count;
  logic [1:0]       out_status;
  logic [KEY_W-1:0] out_key;
  logic [CNT_W-1:0] out_count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic [1:0]       req_mode;
  tok_t             fin;

  tok_t             tok [0:CAPACITY];
  logic [KEY_W-1:0] cell_key [0:CAPACITY-1];
  logic             cell_valid [0:CAPACITY-1];

  assign s_axis_tready = !busy && !m_axis_tvalid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req_mode      = s_axis_tdata[1:0];
  assign fin           = tok[CAPACITY];

  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
    end else if (cfg_wr_en) begin
      order_desc <= cfg_wr_data;
    end
  end

  // token injection into the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active  <= accept;
      tok[0].mode    <= req_mode;
      tok[0].key     <= s_axis_tdata[2+KEY_W-1:2];
      tok[0].carry   <= '0;
      tok[0].removed <= '0;
      tok[0].full    <= (count == CNT_W'(CAPACITY));
      tok[0].status  <= (req_mode == MODE_INSERT) ? ST_FULL : ST_NONE;
      tok[0].st      <= (req_mode == MODE_INSERT || req_mode == MODE_REMOVE ||
                         req_mode == MODE_FIRST) ? TK_SEARCH : TK_DONE;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nkey;
    logic             nvalid;
    if (i < CAPACITY - 1) begin : g_mid
      assign nkey   = cell_key[i+1];
      assign nvalid = cell_valid[i+1];
    end else begin : g_end
      assign nkey   = '0;
      assign nvalid = 1'b0;
    end
    ssk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .order_desc (order_desc),
      .tok_in     (tok[i]),
      .next_key   (nkey),
      .next_valid (nvalid),
      .tok_out    (tok[i+1]),
      .key        (cell_key[i]),
      .valid      (cell_valid[i])
    );
  end

  always_comb begin
    count_next = count;
    if (fin.status == ST_OK) begin
      if (fin.mode == MODE_INSERT) begin
        count_next = CNT_W'(count + 1'b1);
      end else begin
        count_next = CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fin.active) begin
        busy <= 1'b0;
      end
      if (fin.active) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin.active) begin
      out_status <= fin.status;
      out_key    <= fin.removed;
      out_count  <= count_next;
    end
  end

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[1:0]                     = out_status;
    m_axis_tdata[2+KEY_W-1:2]             = out_key;
    m_axis_tdata[2+KEY_W+CNT_W-1:2+KEY_W] = out_count;
  end

endmodule

### rtl/ssk_cell.sv
// one storage cell of the key chain, passing the request token to its neighbor
module ssk_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     order_desc,
  input  ssk_pkg::tok_t            tok_in,
  input  logic [ssk_pkg::KEY_W-1:0] next_key,
  input  logic                     next_valid,
  output ssk_pkg::tok_t            tok_out,
  output logic [ssk_pkg::KEY_W-1:0] key,
  output logic                     valid
);
  import ssk_pkg::*;

  logic             ahead;
  logic             eq;
  logic [KEY_W-1:0] key_next;
  logic             valid_next;
  tok_t             tok_next;

  assign ahead = valid && (tok_in.mode != MODE_FIRST) &&
                 (order_desc ? (key > tok_in.key) : (key < tok_in.key));
  assign eq    = valid && ((tok_in.mode == MODE_FIRST) || (key == tok_in.key));

  always_comb begin
    key_next   = key;
    valid_next = valid;
    tok_next   = tok_in;
    if (tok_in.active) begin
      unique case (tok_in.st)
        TK_SEARCH: begin
          if (!ahead) begin
            if (tok_in.mode == MODE_INSERT) begin
              if (eq) begin
                tok_next.status = ST_DUP;
                tok_next.st     = TK_DONE;
              end else if (tok_in.full) begin
                tok_next.status = ST_FULL;
                tok_next.st     = TK_DONE;
              end else begin
                key_next        = tok_in.key;
                valid_next      = 1'b1;
                tok_next.status = ST_OK;
                tok_next.carry  = key;
                tok_next.st     = valid ? TK_INSERT : TK_DONE;
              end
            end else begin
              if (eq) begin
                tok_next.removed = key;
                tok_next.status  = ST_OK;
                key_next         = next_key;
                valid_next       = next_valid;
                tok_next.st      = next_valid ? TK_SHIFT : TK_DONE;
              end else begin
                tok_next.st = TK_DONE;
              end
            end
          end
        end
        TK_INSERT: begin
          // shift the carried key in, hand our old key on
          key_next       = tok_in.carry;
          valid_next     = 1'b1;
          tok_next.carry = key;
          if (!valid) begin
            tok_next.st = TK_DONE;
          end
        end
        TK_SHIFT: begin
          key_next   = next_key;
          valid_next = next_valid;
          if (!next_valid) begin
            tok_next.st = TK_DONE;
          end
        end
        TK_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

endmodule

### test/testbench.sv
// testbench for sorted_key_set_top: directed table and random requests checked by a predictor
`timescale 1ns / 100ps

module testbench;
  import ssk_pkg::*;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IN_W = ((2 + KEY_W + 7) / 8) * 8;
  localparam int OUT_W = ((2 + KEY_W + CNT_W + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = CAPACITY + 6;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = 250;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_SIZE = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] count;
  } result_t;

  typedef struct {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    bit               typed;
    result_t          want;
  } row_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic             cfg_wr_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  // predictor state
  logic [KEY_W-1:0] held_keys[CAPACITY];
  int unsigned      held_count;
  bit               descending;

  result_t          pending_results[$];
  row_t             directed_rows[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned status_hits[4];
  int unsigned order_writes;
  bit          no_idle;
  result_t     got;
  result_t     want;

  sorted_key_set_top #(.CAPACITY(CAPACITY)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit sorts_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return descending ? (a > b) : (a < b);
  endfunction

  function automatic int unsigned slot_for(logic [KEY_W-1:0] k);
    int unsigned i;
    i = 0;
    while (i < held_count && sorts_ahead(held_keys[i], k)) i++;
    return i;
  endfunction

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i + 1];
    held_count--;
  endfunction

  function automatic result_t apply_request(logic [1:0] mode, logic [KEY_W-1:0] k);
    result_t     r;
    int unsigned pos;
    r.status = ST_NONE;
    r.out_key = '0;
    case (mode)
      MODE_INSERT: begin
        pos = slot_for(k);
        if (pos < held_count && held_keys[pos] == k) begin
          r.status = ST_DUP;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned i = held_count; i > pos; i--) held_keys[i] = held_keys[i - 1];
          held_keys[pos] = k;
          held_count++;
          r.status = ST_OK;
        end
      end
      MODE_REMOVE: begin
        pos = slot_for(k);
        if (pos < held_count && held_keys[pos] == k) begin
          r.out_key = held_keys[pos];
          drop_at(pos);
          r.status = ST_OK;
        end
      end
      MODE_FIRST: begin
        if (held_count > 0) begin
          r.out_key = held_keys[0];
          drop_at(0);
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held_count);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [KEY_W-1:0] k, bit typed,
                                  logic [1:0] st, logic [KEY_W-1:0] ok, int cnt);
    row_t row;
    row.mode = mode;
    row.key = k;
    row.typed = typed;
    row.want.status = st;
    row.want.out_key = ok;
    row.want.count = CNT_W'(cnt);
    directed_rows.push_back(row);
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(logic [1:0] mode, logic [KEY_W-1:0] k, bit typed,
                              result_t typed_want);
    result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - 2 - KEY_W){1'b0}}, k, mode};
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_request(mode, k);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_order(bit value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    descending = value;
    order_writes++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_mode(int unsigned insert_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return MODE_UNUSED;
    if (r < 5 + insert_pct) return MODE_INSERT;
    if (r < 5 + insert_pct + (95 - insert_pct) / 2) return MODE_REMOVE;
    return MODE_FIRST;
  endfunction

  // result side: random back-pressure, one long hold, a stretch with tready held high
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.out_key = m_axis_tdata[KEY_W+1:2];
      got.count = m_axis_tdata[KEY_W+CNT_W+1:KEY_W+2];
      results_seen++;
      status_hits[got.status]++;
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected item: status %0d key %h count %0d",
                   got.status, got.out_key, got.count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.out_key !== want.out_key ||
            got.count !== want.count) begin
          if (error_count < 10)
            $display("mismatch at item %0d: status %0d/%0d key %h/%h count %0d/%0d",
                     results_seen, want.status, got.status, want.out_key, got.out_key,
                     want.count, got.count);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] fill_keys[14];
    result_t          none;
    int unsigned      insert_pct;
    bit               phase_order[PHASES];

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    held_count = 0;
    descending = 1'b0;
    items_sent = 0;
    results_seen = 0;
    error_count = 0;
    order_writes = 0;
    no_idle = 1'b0;
    none = '{default: '0};
    foreach (status_hits[i]) status_hits[i] = 0;

    fill_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                  32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_FFFF,
                  32'hFFFF_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0100,
                  32'hC3C3_3C3C, 32'h3333_3333};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // empty store, duplicates, extremes, absent key, unused mode
    add_row(MODE_FIRST, 32'h0000_0000, 1, ST_NONE, 32'h0, 0);
    add_row(MODE_INSERT, 32'h0000_0000, 1, ST_OK, 32'h0, 1);
    add_row(MODE_INSERT, 32'h0000_0000, 1, ST_DUP, 32'h0, 1);
    add_row(MODE_INSERT, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, 2);
    add_row(MODE_REMOVE, 32'h0000_0005, 1, ST_NONE, 32'h0, 2);
    add_row(MODE_UNUSED, 32'hFFFF_FFFF, 1, ST_NONE, 32'h0, 2);
    // fill to capacity, then insert into a full store
    foreach (fill_keys[i]) add_row(MODE_INSERT, fill_keys[i], 1, ST_OK, 32'h0, i + 3);
    add_row(MODE_INSERT, 32'h1234_5678, 1, ST_DUP, 32'h0, CAPACITY);
    add_row(MODE_INSERT, 32'h0000_0002, 1, ST_FULL, 32'h0, CAPACITY);
    add_row(MODE_FIRST, 32'hFFFF_FFFF, 1, ST_OK, 32'h0, CAPACITY - 1);
    add_row(MODE_REMOVE, 32'hFFFF_FFFF, 1, ST_OK, 32'hFFFF_FFFF, CAPACITY - 2);
    add_row(MODE_REMOVE, 32'h8000_0000, 0, ST_OK, 32'h0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_order(1'b0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].typed,
                   directed_rows[i].want);

    // the first write flips the order with keys still stored
    phase_order = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    for (int p = 0; p < PHASES; p++) begin
      write_order(phase_order[p]);
      no_idle = (p == 5);
      insert_pct = (p % 2 == 0) ? 65 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_mode(insert_pct), pick_key(), 1'b0, none);
    end
    no_idle = 1'b0;
    drain();

    if (pending_results.size() != 0) error_count++;
    $display("%0d requests, %0d results, %0d order writes, %0d errors",
             items_sent, results_seen, order_writes, error_count);
    $display("status ok %0d, duplicate %0d, none %0d, full %0d",
             status_hits[ST_OK], status_hits[ST_DUP], status_hits[ST_NONE],
             status_hits[ST_FULL]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ssk_pkg.sv
rtl/ssk_cell.sv
rtl/sorted_key_set_top.sv
test/testbench.sv
